FILE: hdl/bpc_pkg.sv
// Package: shared constants, codes and types of the byte pair compressor.
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int BUFFER_DEPTH_DEF = 2048;
  localparam int SYMBOL_SPACE_DEF = 512;
  localparam int DICT_DEPTH       = 256;
  localparam int ESC_SYMBOL       = 256;
  localparam int FIRST_SYMBOL     = 257;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_DICT = 2'd2;
  localparam logic [1:0] OP_SYM  = 2'd3;

  localparam logic CFG_MIN_COUNT   = 1'b0;
  localparam logic CFG_MAX_ENTRIES = 1'b1;

  localparam logic [11:0] COUNT_MAX       = 12'hFFF;
  localparam logic [11:0] MIN_COUNT_RST   = 12'd4;
  localparam logic [7:0]  MAX_ENTRIES_RST = 8'd255;
  localparam logic [7:0]  ESC_BYTE        = 8'hFF;

  typedef struct packed {
    logic [11:0] min_count;
    logic [7:0]  max_entries;
  } cfg_t;

endpackage

FILE: hdl/bpc_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module bpc_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bpc_engine.sv
// Sequencer: load, readout and the iterative pair count / replace passes.
`timescale 1ns / 1ps
module bpc_engine
  import bpc_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int SYMBOL_SPACE = SYMBOL_SPACE_DEF,
  localparam int AW  = $clog2(BUFFER_DEPTH),
  localparam int LW  = $clog2(BUFFER_DEPTH + 1),
  localparam int SW  = $clog2(SYMBOL_SPACE),
  localparam int CAW = $clog2(SYMBOL_SPACE * SYMBOL_SPACE),
  localparam int EW  = SW + 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_operation,
  input  logic [7:0]      in_data_byte,
  input  logic            in_sentence_end,
  input  logic            in_block_end,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_entry_count,
  output logic [11:0]     out_symbol_count,
  output logic [8:0]      out_left_symbol,
  output logic [8:0]      out_right_symbol,
  output logic [8:0]      out_symbol,
  output logic            out_sentence_end,
  output logic            out_block_end,
  output logic            out_exhausted,
  output logic            out_overflow,
  output logic            sb_we,
  output logic [AW-1:0]   sb_waddr,
  output logic [EW-1:0]   sb_wdata,
  output logic [AW-1:0]   sb_raddr,
  input  logic [EW-1:0]   sb_rdata,
  output logic            ct_we,
  output logic [CAW-1:0]  ct_addr,
  output logic [11:0]     ct_wdata,
  input  logic [11:0]     ct_rdata,
  output logic            dc_we,
  output logic [7:0]      dc_waddr,
  output logic [2*SW-1:0] dc_wdata,
  output logic [7:0]      dc_raddr,
  input  logic [2*SW-1:0] dc_rdata
);

  localparam int YW = $clog2(SYMBOL_SPACE + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RES    = 4'd1;
  localparam logic [3:0] S_ROUND  = 4'd2;
  localparam logic [3:0] S_SCA    = 4'd3;
  localparam logic [3:0] S_SCB    = 4'd4;
  localparam logic [3:0] S_SCC    = 4'd5;
  localparam logic [3:0] S_SCD    = 4'd6;
  localparam logic [3:0] S_SCE    = 4'd7;
  localparam logic [3:0] S_DECIDE = 4'd8;
  localparam logic [3:0] S_RPA    = 4'd9;
  localparam logic [3:0] S_RPB    = 4'd10;
  localparam logic [3:0] S_RPC    = 4'd11;
  localparam logic [3:0] S_DICT   = 4'd12;

  logic [3:0]     state_r, state_nxt;
  logic [1:0]     op_r, op_nxt;
  logic           loading_r, loading_nxt;
  logic           compressed_r, compressed_nxt;
  logic           ovf_r, ovf_nxt;
  logic           esc_r, esc_nxt;
  logic           clear_r, clear_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [7:0]     dlen_r, dlen_nxt;
  logic [7:0]     rp0_r, rp0_nxt;
  logic [LW-1:0]  rp1_r, rp1_nxt;
  logic [LW-1:0]  i_r, i_nxt;
  logic [LW-1:0]  w_r, w_nxt;
  logic [YW-1:0]  sym_r, sym_nxt;
  logic [SW-1:0]  pa_r, pa_nxt, pb_r, pb_nxt, psym_r, psym_nxt;
  logic [SW-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [1:0]     am_r, am_nxt;
  logic [CAW-1:0] kidx_r, kidx_nxt;
  logic [11:0]    best_r, best_nxt;
  logic [SW-1:0]  best_a_r, best_a_nxt, best_b_r, best_b_nxt;

  logic           ov_r, ov_nxt;
  logic [7:0]     o_ent_r, o_ent_nxt;
  logic [11:0]    o_cnt_r, o_cnt_nxt;
  logic [8:0]     o_l_r, o_l_nxt, o_rt_r, o_rt_nxt, o_sym_r, o_sym_nxt;
  logic           o_se_r, o_se_nxt, o_be_r, o_be_nxt, o_ex_r, o_ex_nxt, o_of_r, o_of_nxt;

  logic [LW-1:0]  eff_len;
  logic [LW:0]    i1;
  logic [SW-1:0]  rd_sym;
  logic [1:0]     rd_mark;
  logic [11:0]    thresh;
  logic [11:0]    cinc;
  logic [CAW-1:0] a_ext;

  assign eff_len = loading_r ? len_r : '0;
  assign i1      = {1'b0, i_r} + (LW + 1)'(1);
  assign rd_sym  = sb_rdata[SW-1:0];
  assign rd_mark = sb_rdata[EW-1:SW];
  assign thresh  = (cfg.min_count == 12'd0) ? 12'd1 : cfg.min_count;
  assign cinc    = (ct_rdata < COUNT_MAX) ? ct_rdata + 12'd1 : ct_rdata;
  assign a_ext   = CAW'(a_r);

  assign in_stall = (state_r != S_IDLE);
  assign ct_addr  = kidx_r;
  assign dc_raddr = rp0_r;
  assign dc_waddr = dlen_r;
  assign dc_wdata = {pa_r, pb_r};

  assign out_valid        = ov_r;
  assign out_entry_count  = o_ent_r;
  assign out_symbol_count = o_cnt_r;
  assign out_left_symbol  = o_l_r;
  assign out_right_symbol = o_rt_r;
  assign out_symbol       = o_sym_r;
  assign out_sentence_end = o_se_r;
  assign out_block_end    = o_be_r;
  assign out_exhausted    = o_ex_r;
  assign out_overflow     = o_of_r;

  always_comb begin
    state_nxt = state_r;  op_nxt = op_r;  loading_nxt = loading_r;
    compressed_nxt = compressed_r;  ovf_nxt = ovf_r;  esc_nxt = esc_r;
    clear_nxt = clear_r;  len_nxt = len_r;  dlen_nxt = dlen_r;
    rp0_nxt = rp0_r;  rp1_nxt = rp1_r;  i_nxt = i_r;  w_nxt = w_r;
    sym_nxt = sym_r;  pa_nxt = pa_r;  pb_nxt = pb_r;  psym_nxt = psym_r;
    a_nxt = a_r;  b_nxt = b_r;  am_nxt = am_r;  kidx_nxt = kidx_r;
    best_nxt = best_r;  best_a_nxt = best_a_r;  best_b_nxt = best_b_r;
    ov_nxt = ov_r && out_stall;
    o_ent_nxt = o_ent_r;  o_cnt_nxt = o_cnt_r;  o_l_nxt = o_l_r;  o_rt_nxt = o_rt_r;
    o_sym_nxt = o_sym_r;  o_se_nxt = o_se_r;  o_be_nxt = o_be_r;
    o_ex_nxt = o_ex_r;  o_of_nxt = o_of_r;
    sb_we = 1'b0;  sb_waddr = w_r[AW-1:0];  sb_wdata = '0;
    sb_raddr = rp1_r[AW-1:0];
    ct_we = 1'b0;  ct_wdata = '0;  dc_we = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_operation)
            OP_LOAD: begin
              loading_nxt = 1'b1;
              if (!loading_r) begin
                dlen_nxt = '0;  rp0_nxt = '0;  rp1_nxt = '0;
                compressed_nxt = 1'b0;  ovf_nxt = 1'b0;
              end
              if (eff_len < LW'(BUFFER_DEPTH)) begin
                sb_we    = 1'b1;
                sb_waddr = eff_len[AW-1:0];
                sb_wdata = {in_block_end, in_sentence_end, SW'(in_data_byte)};
                len_nxt  = eff_len + LW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_RUN: begin
              loading_nxt = 1'b0;
              op_nxt = OP_RUN;
              if (compressed_r) begin
                state_nxt = S_RES;
              end else begin
                pa_nxt = SW'(ESC_BYTE);  pb_nxt = SW'(ESC_BYTE);
                psym_nxt = SW'(ESC_SYMBOL);
                i_nxt = '0;  w_nxt = '0;  esc_nxt = 1'b1;  dlen_nxt = '0;
                state_nxt = S_RPA;
              end
            end
            OP_DICT, OP_SYM: begin
              loading_nxt = 1'b0;
              op_nxt = in_operation;
              state_nxt = S_RES;
            end
          endcase
        end
      end
      S_RPA: begin
        if (i_r >= len_r) begin
          len_nxt = w_r;
          if (esc_r) begin
            sym_nxt = YW'(FIRST_SYMBOL);
            state_nxt = S_ROUND;
          end else begin
            state_nxt = S_DICT;
          end
        end else begin
          sb_raddr = i_r[AW-1:0];
          state_nxt = S_RPB;
        end
      end
      S_RPB: begin
        a_nxt = rd_sym;  am_nxt = rd_mark;
        if (rd_mark == 2'b00 && i1 < {1'b0, len_r} && rd_sym == pa_r) begin
          sb_raddr = i1[AW-1:0];
          state_nxt = S_RPC;
        end else begin
          sb_we = 1'b1;  sb_wdata = {rd_mark, rd_sym};
          i_nxt = i1[LW-1:0];  w_nxt = w_r + LW'(1);
          state_nxt = S_RPA;
        end
      end
      S_RPC: begin
        sb_we = 1'b1;
        if (rd_sym == pb_r) begin
          sb_wdata = {rd_mark, psym_r};
          i_nxt = i_r + LW'(2);
        end else begin
          sb_wdata = {am_r, a_r};
          i_nxt = i1[LW-1:0];
        end
        w_nxt = w_r + LW'(1);
        state_nxt = S_RPA;
      end
      S_ROUND: begin
        if (sym_r < YW'(SYMBOL_SPACE) && dlen_r < cfg.max_entries) begin
          i_nxt = '0;  clear_nxt = 1'b1;
          state_nxt = S_SCA;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_SCA: begin
        if (i1 < {1'b0, len_r}) begin
          sb_raddr = i_r[AW-1:0];
          state_nxt = S_SCB;
        end else if (clear_r) begin
          clear_nxt = 1'b0;  i_nxt = '0;  best_nxt = '0;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_SCB: begin
        a_nxt = rd_sym;
        if (rd_mark != 2'b00) begin
          i_nxt = i1[LW-1:0];
          state_nxt = S_SCA;
        end else begin
          sb_raddr = i1[AW-1:0];
          state_nxt = S_SCC;
        end
      end
      S_SCC: begin
        b_nxt = rd_sym;
        kidx_nxt = a_ext * CAW'(SYMBOL_SPACE) + CAW'(rd_sym);
        state_nxt = S_SCD;
      end
      S_SCD: begin
        if (clear_r) begin
          ct_we = 1'b1;
          i_nxt = i1[LW-1:0];
          state_nxt = S_SCA;
        end else begin
          state_nxt = S_SCE;
        end
      end
      S_SCE: begin
        ct_we = 1'b1;  ct_wdata = cinc;
        if (cinc > best_r) begin
          best_nxt = cinc;  best_a_nxt = a_r;  best_b_nxt = b_r;
        end
        i_nxt = i1[LW-1:0];
        state_nxt = S_SCA;
      end
      S_DECIDE: begin
        if (best_r < thresh) begin
          state_nxt = S_RES;
        end else begin
          pa_nxt = best_a_r;  pb_nxt = best_b_r;  psym_nxt = sym_r[SW-1:0];
          i_nxt = '0;  w_nxt = '0;  esc_nxt = 1'b0;
          state_nxt = S_RPA;
        end
      end
      S_DICT: begin
        dc_we = 1'b1;
        dlen_nxt = dlen_r + 8'd1;
        sym_nxt = sym_r + YW'(1);
        state_nxt = S_ROUND;
      end
      S_RES: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          o_ent_nxt = dlen_r;  o_cnt_nxt = 12'(len_r);  o_of_nxt = ovf_r;
          o_l_nxt = '0;  o_rt_nxt = '0;  o_sym_nxt = '0;
          o_se_nxt = 1'b0;  o_be_nxt = 1'b0;  o_ex_nxt = 1'b0;
          unique case (op_r)
            OP_RUN: begin
              rp0_nxt = '0;  rp1_nxt = '0;  compressed_nxt = 1'b1;
            end
            OP_DICT: begin
              if (rp0_r < dlen_r) begin
                o_l_nxt  = dc_rdata[SW+8:SW];
                o_rt_nxt = dc_rdata[8:0];
                rp0_nxt  = rp0_r + 8'd1;
              end else begin
                o_ex_nxt = 1'b1;
              end
            end
            OP_SYM: begin
              if (rp1_r < len_r) begin
                o_sym_nxt = sb_rdata[8:0];
                o_se_nxt  = sb_rdata[SW];
                o_be_nxt  = sb_rdata[SW+1];
                rp1_nxt   = rp1_r + LW'(1);
              end else begin
                o_ex_nxt = 1'b1;
              end
            end
            default: o_ex_nxt = 1'b0;
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  loading_r <= 1'b0;  compressed_r <= 1'b0;
      ovf_r <= 1'b0;  len_r <= '0;  dlen_r <= '0;  rp0_r <= '0;  rp1_r <= '0;
      ov_r <= 1'b0;  op_r <= OP_LOAD;  esc_r <= 1'b0;  clear_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  loading_r <= loading_nxt;  compressed_r <= compressed_nxt;
      ovf_r <= ovf_nxt;  len_r <= len_nxt;  dlen_r <= dlen_nxt;
      rp0_r <= rp0_nxt;  rp1_r <= rp1_nxt;  ov_r <= ov_nxt;  op_r <= op_nxt;
      esc_r <= esc_nxt;  clear_r <= clear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;  w_r <= w_nxt;  sym_r <= sym_nxt;
    pa_r <= pa_nxt;  pb_r <= pb_nxt;  psym_r <= psym_nxt;
    a_r <= a_nxt;  b_r <= b_nxt;  am_r <= am_nxt;  kidx_r <= kidx_nxt;
    best_r <= best_nxt;  best_a_r <= best_a_nxt;  best_b_r <= best_b_nxt;
    o_ent_r <= o_ent_nxt;  o_cnt_r <= o_cnt_nxt;  o_l_r <= o_l_nxt;
    o_rt_r <= o_rt_nxt;  o_sym_r <= o_sym_nxt;  o_se_r <= o_se_nxt;
    o_be_r <= o_be_nxt;  o_ex_r <= o_ex_nxt;  o_of_r <= o_of_nxt;
  end

endmodule

FILE: hdl/byte_pair_compressor_core.sv
// Top level: configuration registers, buffer/count/dictionary RAMs and sequencer.
//
// Input channel (in_valid / in_stall): operation 0 loads one byte with its
// sentence and block end marks; 1 runs compression; 2 reads the next
// dictionary entry; 3 reads the next compressed symbol. A load following any
// other operation starts a new set. Loads are taken one per cycle and give
// no result. Every other operation gives one result transaction on the
// output channel (out_valid / out_stall), held in an output register.
// A run does per round a count-clear scan and a count scan over the buffer
// positions and, when the best pair reaches the threshold, a replace scan that
// merges it; the count RAM is updated by read-modify-write.
// in_stall is high while an operation is in progress. A result waiting on a
// stalled receiver does not block loads; the next result waits for it.
// Reset clears control state, the buffer length, dictionary length, read
// positions and the overflow flag; configuration returns to min_count 4 and
// max_entries 255. Configuration is written through cfg_we; the user must
// write it only while idle, which the block itself does not enforce.
`timescale 1ns / 1ps
module byte_pair_compressor_core
  import bpc_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int SYMBOL_SPACE = SYMBOL_SPACE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_sentence_end,
  input  logic        in_block_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_entry_count,
  output logic [11:0] out_symbol_count,
  output logic [8:0]  out_left_symbol,
  output logic [8:0]  out_right_symbol,
  output logic [8:0]  out_symbol,
  output logic        out_sentence_end,
  output logic        out_block_end,
  output logic        out_exhausted,
  output logic        out_overflow
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int SW  = $clog2(SYMBOL_SPACE);
  localparam int CAW = $clog2(SYMBOL_SPACE * SYMBOL_SPACE);
  localparam int EW  = SW + 2;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_count   <= MIN_COUNT_RST;
      cfg_r.max_entries <= MAX_ENTRIES_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN_COUNT) begin
        cfg_r.min_count <= cfg_data;
      end
      if (cfg_index == CFG_MAX_ENTRIES) begin
        cfg_r.max_entries <= cfg_data[7:0];
      end
    end
  end

  logic            sb_we;
  logic [AW-1:0]   sb_waddr, sb_raddr;
  logic [EW-1:0]   sb_wdata, sb_rdata;
  logic            ct_we;
  logic [CAW-1:0]  ct_addr;
  logic [11:0]     ct_wdata, ct_rdata;
  logic            dc_we;
  logic [7:0]      dc_waddr, dc_raddr;
  logic [2*SW-1:0] dc_wdata, dc_rdata;

  bpc_ram #(.DEPTH(BUFFER_DEPTH), .WIDTH(EW)) u_sym_ram (
    .clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(sb_wdata),
    .raddr(sb_raddr), .rdata(sb_rdata)
  );

  bpc_ram #(.DEPTH(SYMBOL_SPACE * SYMBOL_SPACE), .WIDTH(12)) u_cnt_ram (
    .clk(clk), .we(ct_we), .waddr(ct_addr), .wdata(ct_wdata),
    .raddr(ct_addr), .rdata(ct_rdata)
  );

  bpc_ram #(.DEPTH(DICT_DEPTH), .WIDTH(2 * SW)) u_dict_ram (
    .clk(clk), .we(dc_we), .waddr(dc_waddr), .wdata(dc_wdata),
    .raddr(dc_raddr), .rdata(dc_rdata)
  );

  bpc_engine #(.BUFFER_DEPTH(BUFFER_DEPTH), .SYMBOL_SPACE(SYMBOL_SPACE)) u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_data_byte(in_data_byte), .in_sentence_end(in_sentence_end),
    .in_block_end(in_block_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_entry_count(out_entry_count), .out_symbol_count(out_symbol_count),
    .out_left_symbol(out_left_symbol), .out_right_symbol(out_right_symbol),
    .out_symbol(out_symbol), .out_sentence_end(out_sentence_end),
    .out_block_end(out_block_end), .out_exhausted(out_exhausted),
    .out_overflow(out_overflow),
    .sb_we(sb_we), .sb_waddr(sb_waddr), .sb_wdata(sb_wdata),
    .sb_raddr(sb_raddr), .sb_rdata(sb_rdata),
    .ct_we(ct_we), .ct_addr(ct_addr), .ct_wdata(ct_wdata), .ct_rdata(ct_rdata),
    .dc_we(dc_we), .dc_waddr(dc_waddr), .dc_wdata(dc_wdata),
    .dc_raddr(dc_raddr), .dc_rdata(dc_rdata)
  );

endmodule

FILE: hdl/bpc_checker.sv
// Port-level assertion checker for the byte pair compressor, with its bind.
`timescale 1ns / 1ps
module bpc_checker
  import bpc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [8:0]  out_left_symbol,
  input logic [8:0]  out_right_symbol,
  input logic [8:0]  out_symbol,
  input logic        out_sentence_end,
  input logic        out_block_end,
  input logic        out_exhausted
);

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == OP_RUN |=> in_stall)
    else $error("run transaction did not make the block busy");

  a_load_stream: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == OP_LOAD |=> !in_stall)
    else $error("load transaction stalled the next one");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exhausted |-> out_left_symbol == 9'd0 &&
      out_right_symbol == 9'd0 && out_symbol == 9'd0 &&
      !out_sentence_end && !out_block_end)
    else $error("exhausted read carried data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind byte_pair_compressor_core bpc_checker u_bpc_checker (.*);

FILE: tb/sv/tb_byte_pair_compressor_core.sv
// Testbench: byte pair compressor core checked against a built-in compression predictor.
`timescale 1ns / 1ps
module tb_byte_pair_compressor_core;
  import bpc_pkg::*;

  typedef struct packed {
    logic [7:0]  entries;
    logic [11:0] nsym;
    logic [8:0]  left;
    logic [8:0]  right;
    logic [8:0]  sym;
    logic        se;
    logic        be;
    logic        exh;
    logic        ovf;
  } result_t;

  localparam int BUF_DEPTH = 2048;
  localparam int SYM_SPACE = 512;
  localparam int WDOG_LIMIT = 400000;
  localparam int SETTLE = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_MIN_COUNT;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_LOAD;
  logic [7:0]  in_data_byte = '0;
  logic        in_sentence_end = 1'b0;
  logic        in_block_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_entry_count;
  logic [11:0] out_symbol_count;
  logic [8:0]  out_left_symbol;
  logic [8:0]  out_right_symbol;
  logic [8:0]  out_symbol;
  logic        out_sentence_end;
  logic        out_block_end;
  logic        out_exhausted;
  logic        out_overflow;

  byte_pair_compressor_core i_dut (.*);

  always #5 clk = ~clk;

  // compression predictor state
  logic [8:0]  buf_sym [BUF_DEPTH];
  logic [1:0]  buf_mark [BUF_DEPTH];
  int          buf_len;
  logic [11:0] pair_cnt [SYM_SPACE*SYM_SPACE];
  logic [8:0]  dict_left [DICT_DEPTH];
  logic [8:0]  dict_right [DICT_DEPTH];
  int          dict_len;
  int          dict_rd;
  int          sym_rd;
  bit          ovf_flag;
  bit          loading;
  bit          compressed;
  int          min_cnt = MIN_COUNT_RST;
  int          max_ent = MAX_ENTRIES_RST;

  result_t     pending_results[$];
  int          errors = 0;
  int          sent = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          quiet_cycles = 0;

  function automatic bit pair_ok(int i);
    return (i + 1 < buf_len) && (buf_mark[i] == 2'b00);
  endfunction

  function automatic void merge_pair(logic [8:0] a, logic [8:0] b, logic [8:0] s);
    int r;
    int w;
    r = 0;
    w = 0;
    while (r < buf_len) begin
      if (pair_ok(r) && buf_sym[r] == a && buf_sym[r+1] == b) begin
        buf_sym[w] = s;
        buf_mark[w] = buf_mark[r+1];
        r += 2;
      end else begin
        buf_sym[w] = buf_sym[r];
        buf_mark[w] = buf_mark[r];
        r++;
      end
      w++;
    end
    buf_len = w;
  endfunction

  function automatic void compress_buffer();
    int s;
    int thr;
    int best;
    int best_cnt;
    int k;
    logic [8:0] a;
    logic [8:0] b;
    s = FIRST_SYMBOL;
    thr = (min_cnt != 0) ? min_cnt : 1;
    merge_pair(9'(ESC_BYTE), 9'(ESC_BYTE), 9'(ESC_SYMBOL));
    dict_len = 0;
    while (s < SYM_SPACE && dict_len < max_ent && dict_len < DICT_DEPTH) begin
      best = 0;
      best_cnt = 0;
      for (int i = 0; i < buf_len; i++) begin
        if (pair_ok(i)) begin
          k = buf_sym[i] * SYM_SPACE + buf_sym[i+1];
          if (pair_cnt[k] < COUNT_MAX) pair_cnt[k]++;
          if (pair_cnt[k] > best_cnt) begin
            best_cnt = pair_cnt[k];
            best = i;
          end
        end
      end
      a = best_cnt ? buf_sym[best] : '0;
      b = best_cnt ? buf_sym[best+1] : '0;
      for (int i = 0; i < buf_len; i++)
        if (pair_ok(i)) pair_cnt[buf_sym[i] * SYM_SPACE + buf_sym[i+1]] = '0;
      if (best_cnt < thr) break;
      merge_pair(a, b, 9'(s));
      dict_left[dict_len] = a;
      dict_right[dict_len] = b;
      dict_len++;
      s++;
    end
  endfunction

  function automatic void predict_op(logic [1:0] op, logic [7:0] d, logic se, logic be);
    result_t r;
    if (op == OP_LOAD) begin
      if (!loading) begin
        buf_len = 0;
        dict_len = 0;
        dict_rd = 0;
        sym_rd = 0;
        ovf_flag = 0;
        compressed = 0;
        loading = 1;
      end
      if (buf_len < BUF_DEPTH) begin
        buf_sym[buf_len] = {1'b0, d};
        buf_mark[buf_len] = {be, se};
        buf_len++;
      end else begin
        ovf_flag = 1;
      end
      return;
    end
    loading = 0;
    r = '0;
    if (op == OP_RUN) begin
      if (!compressed) compress_buffer();
      compressed = 1;
      dict_rd = 0;
      sym_rd = 0;
    end else if (op == OP_DICT) begin
      if (dict_rd < dict_len) begin
        r.left = dict_left[dict_rd];
        r.right = dict_right[dict_rd];
        dict_rd++;
      end else r.exh = 1'b1;
    end else begin
      if (sym_rd < buf_len) begin
        r.sym = buf_sym[sym_rd];
        r.se = buf_mark[sym_rd][0];
        r.be = buf_mark[sym_rd][1];
        sym_rd++;
      end else r.exh = 1'b1;
    end
    r.entries = 8'(dict_len);
    r.nsym = 12'(buf_len);
    r.ovf = ovf_flag;
    pending_results.insert(pending_results.size(), r);
  endfunction

  initial for (int i = 0; i < SYM_SPACE*SYM_SPACE; i++) pair_cnt[i] = '0;

  // input channel driver
  task automatic send_op(logic [1:0] op, logic [7:0] d = '0, logic se = 0, logic be = 0);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_operation = op;
    in_data_byte = d;
    in_sentence_end = se;
    in_block_end = be;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_op(op, d, se, be);
    sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, int val);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = 12'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_MIN_COUNT) min_cnt = val & 12'hFFF;
    else max_ent = val & 8'hFF;
  endtask

  // receiver stall
  always @(negedge clk) out_stall <= ($urandom_range(99) < rcv_stall_pct);

  task automatic check_field(string nm, int e, int a);
    if (e != a) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual symbol %0h",
                 $realtime, out_symbol);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("entry_count", e.entries, out_entry_count);
        check_field("symbol_count", e.nsym, out_symbol_count);
        check_field("left_symbol", e.left, out_left_symbol);
        check_field("right_symbol", e.right, out_right_symbol);
        check_field("out_symbol", e.sym, out_symbol);
        check_field("out_sentence_end", e.se, out_sentence_end);
        check_field("out_block_end", e.be, out_block_end);
        check_field("exhausted", e.exh, out_exhausted);
        check_field("overflow", e.ovf, out_overflow);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("[byte_pair_compressor_core] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_op(OP_DICT);
    send_op(OP_SYM);
    send_op(OP_LOAD, 8'h00);
    send_op(OP_LOAD, 8'hFF);
    send_op(OP_LOAD, 8'hFF);
    send_op(OP_LOAD, 8'hFF);
    send_op(OP_LOAD, 8'hFF, 1'b1);
    send_op(OP_LOAD, 8'hFF);
    send_op(OP_LOAD, 8'h41);
    send_op(OP_LOAD, 8'h42);
    send_op(OP_LOAD, 8'h41);
    send_op(OP_LOAD, 8'h42, 1'b0, 1'b1);
    send_op(OP_LOAD, 8'h41);
    send_op(OP_LOAD, 8'h42, 1'b1, 1'b1);
    send_op(OP_SYM);
    send_op(OP_DICT);
    send_op(OP_RUN);
    repeat (2) send_op(OP_DICT);
    repeat (3) send_op(OP_SYM);
    send_op(OP_RUN);
    send_op(OP_SYM);
  endtask

  task automatic load_pattern(int n);
    for (int i = 0; i < n; i++)
      send_op(OP_LOAD, 8'(i % 3), 1'b0, (i % 7) == 6);
  endtask

  task automatic test_config_extremes();
    int mins[4] = '{0, 1, 2, 4095};
    int maxs[4] = '{0, 1, 255, 3};
    for (int c = 0; c < 4; c++) begin
      write_cfg(CFG_MIN_COUNT, mins[c]);
      write_cfg(CFG_MAX_ENTRIES, maxs[c]);
      load_pattern(14);
      send_op(OP_RUN);
      repeat (3) send_op(OP_DICT);
      repeat (2) send_op(OP_SYM);
    end
  endtask

  task automatic test_overflow();
    write_cfg(CFG_MAX_ENTRIES, 0);
    for (int i = 0; i < BUF_DEPTH + 2; i++)
      send_op(OP_LOAD, 8'($urandom_range(255)), $urandom_range(15) == 0, 1'b0);
    send_op(OP_RUN);
    send_op(OP_DICT);
    repeat (2) send_op(OP_SYM);
  endtask

  task automatic random_set();
    int n;
    int nalpha;
    logic [7:0] alpha[6];
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(4, 12))
        send_op(2'($urandom_range(3)), 8'($urandom), 1'($urandom), 1'($urandom));
      return;
    end
    if ($urandom_range(3) == 0) begin
      if ($urandom_range(1)) write_cfg(CFG_MIN_COUNT,
          $urandom_range(9) == 0 ? $urandom_range(4095) : $urandom_range(4));
      else write_cfg(CFG_MAX_ENTRIES, $urandom_range(255));
    end
    n = ($urandom_range(29) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
    nalpha = $urandom_range(2, 6);
    for (int i = 0; i < nalpha; i++)
      alpha[i] = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
    for (int i = 0; i < n; i++)
      send_op(OP_LOAD,
              ($urandom_range(9) == 0) ? 8'($urandom) : alpha[$urandom_range(nalpha - 1)],
              $urandom_range(9) == 0, $urandom_range(19) == 0);
    if ($urandom_range(9) == 0) send_op(OP_SYM);
    send_op(OP_RUN);
    repeat ($urandom_range(0, 6)) send_op(OP_DICT);
    repeat ($urandom_range(0, n + 2)) send_op(OP_SYM);
    if ($urandom_range(5) == 0) begin
      send_op(OP_RUN);
      send_op(OP_SYM);
    end
  endtask

  task automatic test_random();
    int start;
    start = sent;
    while (sent - start < 950) begin
      if (sent - start < 317) begin
        snd_idle_pct = 12;
        rcv_stall_pct = 64;
      end else if (sent - start < 634) begin
        snd_idle_pct = 64;
        rcv_stall_pct = 12;
      end else begin
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
      end
      random_set();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_extremes();
    test_overflow();
    write_cfg(CFG_MIN_COUNT, 2);
    write_cfg(CFG_MAX_ENTRIES, 255);
    test_random();
    wait_idle();
    if (errors == 0)
      $display("[byte_pair_compressor_core] OK");
    else
      $display("[byte_pair_compressor_core] ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/bpc_pkg.sv
hdl/bpc_ram.sv
hdl/bpc_engine.sv
hdl/byte_pair_compressor_core.sv
hdl/bpc_checker.sv
tb/sv/tb_byte_pair_compressor_core.sv
